/* rtl/rrpt_pkg.sv */
// Shared types and constants for the replication progress tracker.
// No dependencies; used by every file of the block.
package rrpt_pkg;

  // Default index width; the next index is one bit wider.
  localparam int unsigned IndexWidthDef = 63;

  typedef enum logic [1:0] {
    MODE_RETRY = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_REPL  = 2'd2,
    MODE_SNAP  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_TO_RETRY   = 4'd0,
    OP_TO_WAIT    = 4'd1,
    OP_TO_REPL    = 4'd2,
    OP_TO_SNAP    = 4'd3,
    OP_RETRY_WAIT = 4'd4,
    OP_WAIT_RETRY = 4'd5,
    OP_REPL_RETRY = 4'd6,
    OP_CLEAR_SNAP = 4'd7,
    OP_ACK        = 4'd8,
    OP_OPTIMISTIC = 4'd9,
    OP_REJECT     = 4'd10,
    OP_RESPONDED  = 4'd11,
    OP_LOAD       = 4'd12
  } op_e;

  // Per-event status handed from the update logic to the result register.
  typedef struct packed {
    logic  accepted;
    logic  error;
    logic  paused;
    mode_e mode;
  } flags_t;

endpackage

/* rtl/rrpt_step.sv */
// Combinational progress update for one event.
// Depends on rrpt_pkg (mode_e, op_e, flags_t).
module rrpt_step #(
  parameter int unsigned INDEX_WIDTH = rrpt_pkg::IndexWidthDef
) (
  input  rrpt_pkg::op_e             op_i,
  input  logic [INDEX_WIDTH-1:0]    first_i,
  input  logic [INDEX_WIDTH-1:0]    second_i,
  input  rrpt_pkg::mode_e           mode_i,
  input  logic [INDEX_WIDTH-1:0]    match_i,
  input  logic [INDEX_WIDTH:0]      next_i,
  input  logic [INDEX_WIDTH-1:0]    snap_i,
  output rrpt_pkg::flags_t          flags_o,
  output logic [INDEX_WIDTH-1:0]    match_o,
  output logic [INDEX_WIDTH:0]      next_o,
  output logic [INDEX_WIDTH-1:0]    snap_o
);

  localparam int unsigned NW = INDEX_WIDTH + 1;

  logic [NW-1:0]          first_x, first_inc, match_inc, hi_inc, retry_next;
  logic [NW-1:0]          next_dec, lim, rej_min;
  logic [INDEX_WIDTH-1:0] hi;
  rrpt_pkg::mode_e        mode_d;
  logic                   acc, err;

  assign first_x   = {1'b0, first_i};
  assign first_inc = first_x + NW'(1);
  assign match_inc = {1'b0, match_i} + NW'(1);
  assign hi        = (match_i > snap_i) ? match_i : snap_i;
  assign hi_inc    = {1'b0, hi} + NW'(1);
  // leaving snapshot mode resumes past whichever is further
  assign retry_next = (mode_i == rrpt_pkg::MODE_SNAP) ? hi_inc : match_inc;
  // wraps to all ones when next is zero, so no rejection matches then
  assign next_dec  = next_i - NW'(1);
  assign lim       = {1'b0, second_i} + NW'(1);
  assign rej_min   = (first_x < lim) ? first_x : lim;

  // next state
  always_comb begin
    mode_d  = mode_i;
    match_o = match_i;
    next_o  = next_i;
    snap_o  = snap_i;
    acc     = 1'b0;
    err     = 1'b0;
    case (op_i)
      rrpt_pkg::OP_TO_RETRY: begin
        next_o = retry_next;
        snap_o = '0;
        mode_d = rrpt_pkg::MODE_RETRY;
      end
      rrpt_pkg::OP_TO_WAIT: begin
        next_o = retry_next;
        snap_o = '0;
        mode_d = rrpt_pkg::MODE_WAIT;
      end
      rrpt_pkg::OP_TO_REPL: begin
        next_o = match_inc;
        snap_o = '0;
        mode_d = rrpt_pkg::MODE_REPL;
      end
      rrpt_pkg::OP_TO_SNAP: begin
        snap_o = first_i;
        mode_d = rrpt_pkg::MODE_SNAP;
      end
      rrpt_pkg::OP_RETRY_WAIT: begin
        if (mode_i == rrpt_pkg::MODE_RETRY) mode_d = rrpt_pkg::MODE_WAIT;
      end
      rrpt_pkg::OP_WAIT_RETRY: begin
        if (mode_i == rrpt_pkg::MODE_WAIT) mode_d = rrpt_pkg::MODE_RETRY;
      end
      rrpt_pkg::OP_REPL_RETRY: begin
        if (mode_i == rrpt_pkg::MODE_REPL) begin
          next_o = match_inc;
          snap_o = '0;
          mode_d = rrpt_pkg::MODE_RETRY;
        end
      end
      rrpt_pkg::OP_CLEAR_SNAP: snap_o = '0;
      rrpt_pkg::OP_ACK: begin
        if (next_i < first_inc) next_o = first_inc;
        if (match_i < first_i) begin
          if (mode_i == rrpt_pkg::MODE_WAIT) mode_d = rrpt_pkg::MODE_RETRY;
          match_o = first_i;
          acc     = 1'b1;
        end
      end
      rrpt_pkg::OP_OPTIMISTIC: begin
        if (mode_i == rrpt_pkg::MODE_REPL) next_o = first_inc;
        else if (mode_i == rrpt_pkg::MODE_RETRY) mode_d = rrpt_pkg::MODE_WAIT;
        else err = 1'b1;
      end
      rrpt_pkg::OP_REJECT: begin
        if (mode_i == rrpt_pkg::MODE_REPL) begin
          if (first_i > match_i) begin
            next_o = match_inc;
            acc    = 1'b1;
          end
        end else if (first_x == next_dec) begin
          if (mode_i == rrpt_pkg::MODE_WAIT) mode_d = rrpt_pkg::MODE_RETRY;
          next_o = (rej_min == '0) ? NW'(1) : rej_min;
          acc    = 1'b1;
        end
      end
      rrpt_pkg::OP_RESPONDED: begin
        if (mode_i == rrpt_pkg::MODE_RETRY) begin
          next_o = match_inc;
          snap_o = '0;
          mode_d = rrpt_pkg::MODE_REPL;
        end else if (mode_i == rrpt_pkg::MODE_SNAP && match_i >= snap_i) begin
          next_o = hi_inc;
          snap_o = '0;
          mode_d = rrpt_pkg::MODE_RETRY;
        end
      end
      rrpt_pkg::OP_LOAD: begin
        match_o = first_i;
        next_o  = {1'b0, second_i};
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    flags_o.accepted = acc;
    flags_o.error    = err;
    flags_o.mode     = mode_d;
    flags_o.paused   = (mode_d == rrpt_pkg::MODE_WAIT) || (mode_d == rrpt_pkg::MODE_SNAP);
  end

endmodule

/* rtl/raft_replication_progress_tracker_core.sv */
// Replication progress tracker for one follower: top level with stream ports.
// Depends on rrpt_pkg and rrpt_step.
//
// Takes one event per request on the slave stream and returns exactly one result per
// event on the master stream, in order, through the input register, then update and
// result register; one event per clock unless the master stalls. The progress state
// (mode, match, next, pending snapshot) is read and written in the same cycle by the
// update logic, so back-to-back events see each other's effect. Reset puts the
// tracker in retry mode with match 0, next 1 and no pending snapshot. The operation
// code travels in s_axis_tuser; codes 13 to 15 leave the state alone and report it.
module raft_replication_progress_tracker_core #(
  parameter int unsigned INDEX_WIDTH = rrpt_pkg::IndexWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [IW-1:0] first_index, [2IW-1:IW] second_index, zero pad to bytes
  input  logic [((2*INDEX_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // [3:0] operation
  input  logic [3:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [0] accepted, [1] error, [2] paused, [4:3] mode, then match_out (IW),
  // next_out (IW+1), snapshot_out (IW), zero pad to bytes
  output logic [((3*INDEX_WIDTH+6+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int unsigned IW    = INDEX_WIDTH;
  localparam int unsigned NW    = IW + 1;
  localparam int unsigned OUT_W = ((3*IW+6+7)/8)*8;

  // input register
  logic          s1_valid_q, s1_valid_d;
  logic [3:0]    s1_op_q;
  logic [IW-1:0] s1_a_q, s1_b_q;

  // progress state
  rrpt_pkg::mode_e mode_q;
  logic [IW-1:0]   match_q, snap_q;
  logic [NW-1:0]   next_q;

  rrpt_pkg::flags_t flags;
  logic [IW-1:0]    match_d, snap_d;
  logic [NW-1:0]    next_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  logic s_fire, adv;

  // an event moves to the result register when that register is free or draining
  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = s_fire || (s1_valid_q && !adv);
  assign out_valid_d   = adv || (out_valid_q && !m_axis_tready);

  rrpt_step #(.INDEX_WIDTH(IW)) u_step (
    .op_i    (rrpt_pkg::op_e'(s1_op_q)),
    .first_i (s1_a_q),
    .second_i(s1_b_q),
    .mode_i  (mode_q),
    .match_i (match_q),
    .next_i  (next_q),
    .snap_i  (snap_q),
    .flags_o (flags),
    .match_o (match_d),
    .next_o  (next_d),
    .snap_o  (snap_d)
  );

  assign out_data_d = OUT_W'({snap_d, next_d, match_d, flags.mode, flags.paused,
                              flags.error, flags.accepted});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= rrpt_pkg::MODE_RETRY;
      match_q     <= '0;
      next_q      <= NW'(1);
      snap_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        mode_q  <= flags.mode;
        match_q <= match_d;
        next_q  <= next_d;
        snap_q  <= snap_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_op_q <= s_axis_tuser;
      s1_a_q  <= s_axis_tdata[IW-1:0];
      s1_b_q  <= s_axis_tdata[2*IW-1:IW];
    end
    if (adv) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/rrpt_checker.sv */
// Port-level checks for the replication progress tracker, bound to the top level.
// Depends on rrpt_pkg and raft_replication_progress_tracker_core.
module rrpt_checker #(
  parameter int unsigned INDEX_WIDTH = rrpt_pkg::IndexWidthDef
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*INDEX_WIDTH+6+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned SNAP_LO = 5 + 2*INDEX_WIDTH + 1;

  logic            r_err, r_paused;
  rrpt_pkg::mode_e r_mode;
  logic            snap_zero;

  assign r_err     = m_axis_tdata[1];
  assign r_paused  = m_axis_tdata[2];
  assign r_mode    = rrpt_pkg::mode_e'(m_axis_tdata[4:3]);
  assign snap_zero = (m_axis_tdata[SNAP_LO+INDEX_WIDTH-1:SNAP_LO] == '0);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_paused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> r_paused == (r_mode == rrpt_pkg::MODE_WAIT ||
                                   r_mode == rrpt_pkg::MODE_SNAP))
    else $error("paused flag disagrees with mode");

  // a rejected optimistic update leaves the tracker paused
  a_err_paused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r_err |-> r_paused)
    else $error("error reported outside a paused mode");

  // only snapshot mode can carry a pending snapshot
  a_snap_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r_mode != rrpt_pkg::MODE_SNAP |-> snap_zero)
    else $error("pending snapshot outside snapshot mode");

endmodule

bind raft_replication_progress_tracker_core rrpt_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_rrpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
